// ===== hdl/mspv2fp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mspv2fp_pkg
// Shared constants and the CRC-8 DVB-S2 byte update for the MSPv2 frame parser.
// ----------------------------------------------------------------------------
package mspv2fp_pkg;

  // frame layout
  localparam int unsigned HeaderBytes = 5;
  localparam logic [7:0]  ChDollar    = 8'h24;  // '$'
  localparam logic [7:0]  ChX         = 8'h58;  // 'X'
  localparam logic [7:0]  ChCmd       = 8'h3C;  // '<'
  localparam logic [7:0]  ChResp      = 8'h3E;  // '>'
  localparam logic [7:0]  CrcPoly     = 8'hD5;

  // parser state codes
  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StStart   = 3'd1;
  localparam logic [2:0] StType    = 3'd2;
  localparam logic [2:0] StHeader  = 3'd3;
  localparam logic [2:0] StPayload = 3'd4;
  localparam logic [2:0] StCrc     = 3'd5;

  // result event codes
  localparam logic [2:0] EvNone   = 3'd0;
  localparam logic [2:0] EvHeader = 3'd1;
  localparam logic [2:0] EvData   = 3'd2;
  localparam logic [2:0] EvGood   = 3'd3;
  localparam logic [2:0] EvBad    = 3'd4;

  // one byte through the msb-first crc-8 shift register
  function automatic logic [7:0] crc8_update(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] v;
    v = acc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CrcPoly;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

// ===== hdl/mspv2fp_rx_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mspv2fp_rx_if
// Byte channel into the parser: valid/ready handshake with one received byte.
// ----------------------------------------------------------------------------
interface mspv2fp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hdl/mspv2fp_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mspv2fp_res_if
// Result channel out of the parser: valid/ready handshake with one result.
// ----------------------------------------------------------------------------
interface mspv2fp_res_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [2:0]  event_res;
  logic [7:0]  data_byte;
  logic [15:0] byte_index;
  logic        is_response;
  logic [7:0]  frame_flags;
  logic [15:0] function_code;
  logic [15:0] payload_length;

  modport source (output valid, output accepted, output event_res, output data_byte,
                  output byte_index, output is_response, output frame_flags,
                  output function_code, output payload_length, input ready);
  modport sink   (input valid, input accepted, input event_res, input data_byte,
                  input byte_index, input is_response, input frame_flags,
                  input function_code, input payload_length, output ready);
endinterface

// ===== hdl/mspv2_frame_parser_top.sv =====
`timescale 1ns / 1ps
// The result for a byte is registered and shown in the cycle after its transaction.
// Throughput: one byte per cycle while results drain; the state step and the byte-wide crc
// update sit between the parser registers and the result register.
// A new byte is taken whenever the result register is empty or being drained.
// Reset (rst_ni low, asynchronous) returns the parser to idle, clears crc,
// counter, type and header field registers and empties the result register.
// ----------------------------------------------------------------------------
// mspv2_frame_parser_top
// MSPv2 frame recognizer: one received byte per transaction, one result each.
// ----------------------------------------------------------------------------
module mspv2_frame_parser_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  mspv2fp_rx_if.sink            rx_i,
  mspv2fp_res_if.source         res_o
);

  // parser state
  logic [2:0]  state_q, state_d;
  logic [15:0] count_q, count_d;
  logic [7:0]  crc_q, crc_d;
  logic [7:0]  hdr_q [4];
  logic        type_q, type_d;
  logic [7:0]  flags_q, flags_d;
  logic [15:0] func_q, func_d;
  logic [15:0] len_q, len_d;

  // result register
  logic        out_valid_q;
  logic        acc_q, acc_d;
  logic [2:0]  ev_q, ev_d;
  logic [7:0]  data_q, data_d;
  logic [15:0] idx_q, idx_d;

  logic        take;
  logic        took;
  logic        hdr_we;
  logic [7:0]  b;
  logic [7:0]  crc_next;
  logic [15:0] count_inc;

  assign rx_i.ready = ~out_valid_q | res_o.ready;
  assign take       = rx_i.valid & rx_i.ready;
  assign b          = rx_i.rx_byte;
  assign crc_next   = mspv2fp_pkg::crc8_update(crc_q, b);
  assign count_inc  = count_q + 16'd1;

  // one parser step for the incoming byte
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    crc_d   = crc_q;
    type_d  = type_q;
    flags_d = flags_q;
    func_d  = func_q;
    len_d   = len_q;
    took    = 1'b0;
    hdr_we  = 1'b0;
    ev_d    = mspv2fp_pkg::EvNone;
    data_d  = 8'd0;
    idx_d   = 16'd0;
    case (state_q)
      mspv2fp_pkg::StIdle: begin
        if (b == mspv2fp_pkg::ChDollar) begin
          state_d = mspv2fp_pkg::StStart;
          took    = 1'b1;
        end
      end
      mspv2fp_pkg::StStart: begin
        state_d = (b == mspv2fp_pkg::ChX) ? mspv2fp_pkg::StType : mspv2fp_pkg::StIdle;
      end
      mspv2fp_pkg::StType: begin
        flags_d = 8'd0;
        func_d  = 16'd0;
        len_d   = 16'd0;
        count_d = 16'd0;
        crc_d   = 8'd0;
        type_d  = 1'b0;
        state_d = mspv2fp_pkg::StHeader;
        if (b == mspv2fp_pkg::ChResp) begin
          type_d = 1'b1;
        end else if (b != mspv2fp_pkg::ChCmd) begin
          state_d = mspv2fp_pkg::StIdle;
        end
      end
      mspv2fp_pkg::StHeader: begin
        crc_d   = crc_next;
        hdr_we  = (count_q < 16'd4);
        count_d = count_inc;
        if (count_inc >= 16'(mspv2fp_pkg::HeaderBytes)) begin
          flags_d = hdr_q[0];
          func_d  = {hdr_q[2], hdr_q[1]};
          len_d   = {b, hdr_q[3]};
          count_d = 16'd0;
          state_d = ({b, hdr_q[3]} == 16'd0) ? mspv2fp_pkg::StCrc
                                              : mspv2fp_pkg::StPayload;
          ev_d    = mspv2fp_pkg::EvHeader;
        end
      end
      mspv2fp_pkg::StPayload: begin
        crc_d   = crc_next;
        ev_d    = mspv2fp_pkg::EvData;
        data_d  = b;
        idx_d   = count_q;
        count_d = count_inc;
        if (count_inc == len_q) begin
          state_d = mspv2fp_pkg::StCrc;
        end
      end
      mspv2fp_pkg::StCrc: begin
        took    = 1'b1;
        ev_d    = (crc_q == b) ? mspv2fp_pkg::EvGood : mspv2fp_pkg::EvBad;
        state_d = mspv2fp_pkg::StIdle;
      end
      default: begin
        state_d = mspv2fp_pkg::StIdle;
      end
    endcase
    acc_d = took | (state_d != mspv2fp_pkg::StIdle);
  end

  // parser registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mspv2fp_pkg::StIdle;
      count_q <= 16'd0;
      crc_q   <= 8'd0;
      type_q  <= 1'b0;
      flags_q <= 8'd0;
      func_q  <= 16'd0;
      len_q   <= 16'd0;
    end else if (take) begin
      state_q <= state_d;
      count_q <= count_d;
      crc_q   <= crc_d;
      type_q  <= type_d;
      flags_q <= flags_d;
      func_q  <= func_d;
      len_q   <= len_d;
    end
  end

  // header byte store, written in order within a frame
  always_ff @(posedge clk_i) begin
    if (take && hdr_we) begin
      hdr_q[count_q[1:0]] <= b;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      acc_q  <= acc_d;
      ev_q   <= ev_d;
      data_q <= data_d;
      idx_q  <= idx_d;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.accepted       = acc_q;
  assign res_o.event_res      = ev_q;
  assign res_o.data_byte      = data_q;
  assign res_o.byte_index     = idx_q;
  assign res_o.is_response    = type_q;
  assign res_o.frame_flags    = flags_q;
  assign res_o.function_code  = func_q;
  assign res_o.payload_length = len_q;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MSPv2 frame parser. Bytes go in over the rx
// channel in random bursts. An in-bench parser model predicts each result,
// and every result transaction is compared field by field with the oldest
// prediction. The result side stalls on a changing pattern and once holds
// off long enough to back the parser up.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WatchdogLimit = 2000;
  localparam int HoldCycles    = 300;

  // expected contents of one result transaction
  typedef struct packed {
    logic        accepted;
    logic [2:0]  event_res;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic        is_response;
    logic [7:0]  frame_flags;
    logic [15:0] function_code;
    logic [15:0] payload_length;
  } parse_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mspv2fp_rx_if  rx ();
  mspv2fp_res_if res ();

  mspv2_frame_parser_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx),
    .res_o  (res)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // parser model state
  logic [2:0]  mdl_state = mspv2fp_pkg::StIdle;
  logic [15:0] mdl_count = '0;
  logic [7:0]  mdl_crc   = '0;
  logic [7:0]  mdl_hdr [4];
  logic        mdl_resp  = 1'b0;
  logic [7:0]  mdl_flags = '0;
  logic [15:0] mdl_func  = '0;
  logic [15:0] mdl_len   = '0;

  parse_result_t pending_results[$];
  int unsigned   bytes_sent  = 0;
  int unsigned   error_count = 0;
  int            burst_left  = 0;
  int            quiet_cycles = 0;
  logic          hold_active = 1'b0;
  event          hold_start;

  // crc-8 dvb-s2, msb first
  function automatic logic [7:0] crc_dvb_s2(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    c = acc ^ b;
    repeat (8) c = c[7] ? ({c[6:0], 1'b0} ^ mspv2fp_pkg::CrcPoly) : {c[6:0], 1'b0};
    return c;
  endfunction

  // advance the parser model by one byte
  task automatic parse_byte(input logic [7:0] b, output parse_result_t r);
    logic took;
    took = 1'b0;
    r = '0;
    case (mdl_state)
      mspv2fp_pkg::StIdle: begin
        if (b == mspv2fp_pkg::ChDollar) begin
          mdl_state = mspv2fp_pkg::StStart;
          took = 1'b1;
        end
      end
      mspv2fp_pkg::StStart: begin
        mdl_state = (b == mspv2fp_pkg::ChX) ? mspv2fp_pkg::StType : mspv2fp_pkg::StIdle;
      end
      mspv2fp_pkg::StType: begin
        mdl_flags = '0;
        mdl_func  = '0;
        mdl_len   = '0;
        mdl_count = '0;
        mdl_crc   = '0;
        mdl_resp  = 1'b0;
        mdl_state = mspv2fp_pkg::StHeader;
        if (b == mspv2fp_pkg::ChResp) mdl_resp = 1'b1;
        else if (b != mspv2fp_pkg::ChCmd) mdl_state = mspv2fp_pkg::StIdle;
      end
      mspv2fp_pkg::StHeader: begin
        mdl_crc = crc_dvb_s2(mdl_crc, b);
        if (mdl_count < 4) mdl_hdr[mdl_count[1:0]] = b;
        mdl_count = mdl_count + 16'd1;
        if (mdl_count >= mspv2fp_pkg::HeaderBytes) begin
          mdl_flags = mdl_hdr[0];
          mdl_func  = {mdl_hdr[2], mdl_hdr[1]};
          mdl_len   = {b, mdl_hdr[3]};
          mdl_count = '0;
          mdl_state = (mdl_len == 16'd0) ? mspv2fp_pkg::StCrc : mspv2fp_pkg::StPayload;
          r.event_res = mspv2fp_pkg::EvHeader;
        end
      end
      mspv2fp_pkg::StPayload: begin
        mdl_crc = crc_dvb_s2(mdl_crc, b);
        r.event_res  = mspv2fp_pkg::EvData;
        r.data_byte  = b;
        r.byte_index = mdl_count;
        mdl_count = mdl_count + 16'd1;
        if (mdl_count == mdl_len) mdl_state = mspv2fp_pkg::StCrc;
      end
      mspv2fp_pkg::StCrc: begin
        took = 1'b1;
        r.event_res = (mdl_crc == b) ? mspv2fp_pkg::EvGood : mspv2fp_pkg::EvBad;
        mdl_state = mspv2fp_pkg::StIdle;
      end
      default: mdl_state = mspv2fp_pkg::StIdle;
    endcase
    r.accepted       = took || (mdl_state != mspv2fp_pkg::StIdle);
    r.is_response    = mdl_resp;
    r.frame_flags    = mdl_flags;
    r.function_code  = mdl_func;
    r.payload_length = mdl_len;
  endtask

  // predict on every rx transaction
  always @(posedge clk_i) begin : predict_results
    parse_result_t r;
    if (rx.valid === 1'b1 && rx.ready === 1'b1) begin
      parse_byte(rx.rx_byte, r);
      pending_results.push_back(r);
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endtask

  // compare every result transaction with the oldest prediction
  always @(posedge clk_i) begin : check_results
    parse_result_t want;
    if (res.valid === 1'b1 && res.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no byte pending");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("accepted", 16'(want.accepted), 16'(res.accepted));
        check_field("event_res", 16'(want.event_res), 16'(res.event_res));
        check_field("data_byte", 16'(want.data_byte), 16'(res.data_byte));
        check_field("byte_index", want.byte_index, res.byte_index);
        check_field("is_response", 16'(want.is_response), 16'(res.is_response));
        check_field("frame_flags", 16'(want.frame_flags), 16'(res.frame_flags));
        check_field("function_code", want.function_code, res.function_code);
        check_field("payload_length", want.payload_length, res.payload_length);
      end
    end
  end

  // result side stall pattern: always ready, random, or ready once per turn of the phase counter
  always @(posedge clk_i) begin : drive_res_ready
    static int mode = 0;
    static int mode_left = 0;
    static int phase = 0;
    logic rdy;
    if (mode_left == 0) begin
      mode = $urandom_range(0, 2);
      mode_left = $urandom_range(32, 256);
    end else begin
      mode_left--;
    end
    phase = (phase + 1) % 3;
    case (mode)
      0:       rdy = 1'b1;
      1:       rdy = 1'($urandom_range(0, 1));
      default: rdy = (phase == 0);
    endcase
    res.ready <= rdy && !hold_active;
  end

  // long hold-off of the result side
  always begin
    @(hold_start);
    hold_active <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_active <= 1'b0;
  end

  // no transaction on either side for too long ends the run
  always @(posedge clk_i) begin
    if ((rx.valid === 1'b1 && rx.ready === 1'b1) ||
        (res.valid === 1'b1 && res.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // one rx transaction, with bursts and gaps on the sender side
  task automatic send_rx_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) begin
        gap = 0;
        burst_left = $urandom_range(100, 300);
      end else begin
        gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
        if ($urandom_range(0, 15) == 0) gap = 30;
        burst_left = $urandom_range(1, 16);
      end
      if (gap > 0) begin
        rx.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    do @(posedge clk_i); while (rx.ready !== 1'b1);
    bytes_sent++;
  endtask

  // whole frame with random payload; crc optionally corrupted
  task automatic send_frame(input logic [7:0] kind, input logic [7:0] flags,
                            input logic [15:0] func, input logic [15:0] len,
                            input bit bad_crc);
    logic [7:0] hdr [5];
    logic [7:0] crc;
    logic [7:0] pb;
    hdr = '{flags, func[7:0], func[15:8], len[7:0], len[15:8]};
    crc = '0;
    send_rx_byte(mspv2fp_pkg::ChDollar);
    send_rx_byte(mspv2fp_pkg::ChX);
    send_rx_byte(kind);
    for (int i = 0; i < 5; i++) begin
      crc = crc_dvb_s2(crc, hdr[i]);
      send_rx_byte(hdr[i]);
    end
    for (int n = 0; n < int'(len); n++) begin
      pb = 8'($urandom);
      crc = crc_dvb_s2(crc, pb);
      send_rx_byte(pb);
    end
    if (bad_crc) crc = crc ^ 8'($urandom_range(1, 255));
    send_rx_byte(crc);
  endtask

  // idle noise at the byte extremes, empty payload, bad crc on a response
  task automatic test_directed_frames();
    send_rx_byte(8'h00);
    send_rx_byte(8'hFF);
    send_frame(mspv2fp_pkg::ChCmd, 8'h00, 16'h0000, 16'h0000, 1'b0);
    send_frame(mspv2fp_pkg::ChResp, 8'hFF, 16'hFFFF, 16'h0002, 1'b1);
  endtask

  // wrong second byte, unknown type, repeated start
  task automatic test_broken_headers();
    send_rx_byte(mspv2fp_pkg::ChDollar);
    send_rx_byte(8'h00);
    send_rx_byte(mspv2fp_pkg::ChDollar);
    send_rx_byte(mspv2fp_pkg::ChX);
    send_rx_byte(8'hFF);
    send_rx_byte(mspv2fp_pkg::ChDollar);
    send_rx_byte(mspv2fp_pkg::ChDollar);
    send_rx_byte(mspv2fp_pkg::ChX);
    send_rx_byte(mspv2fp_pkg::ChDollar);
    send_rx_byte(mspv2fp_pkg::ChX);
    send_rx_byte(mspv2fp_pkg::ChX);
  endtask

  // long frame whose payload length has a nonzero high byte
  task automatic test_long_frame();
    send_frame(mspv2fp_pkg::ChResp, 8'($urandom), 16'($urandom), 16'h0100, 1'b0);
  endtask

  // result side holds off while frames keep coming
  task automatic test_backpressure();
    -> hold_start;
    repeat (3) begin
      send_frame(mspv2fp_pkg::ChCmd, 8'($urandom), 16'($urandom),
                 16'($urandom_range(1, 8)), 1'b0);
    end
  endtask

  // mostly well-formed frames with random content, plus noise and broken starts
  task automatic test_random_traffic(input int unsigned count);
    int unsigned stop_at;
    int sel;
    int cut;
    logic [7:0] kind;
    logic [15:0] len;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      sel = $urandom_range(0, 99);
      if (sel < 75) begin
        if ($urandom_range(0, 19) == 0) kind = 8'($urandom);
        else kind = ($urandom_range(0, 1) == 0) ? mspv2fp_pkg::ChCmd : mspv2fp_pkg::ChResp;
        sel = $urandom_range(0, 99);
        if (sel < 70)      len = 16'($urandom_range(0, 8));
        else if (sel < 95) len = 16'($urandom_range(9, 40));
        else               len = 16'($urandom_range(41, 200));
        send_frame(kind, 8'($urandom), 16'($urandom), len, $urandom_range(0, 3) == 0);
      end else if (sel < 87) begin
        repeat ($urandom_range(1, 6)) send_rx_byte(8'($urandom));
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            send_rx_byte(mspv2fp_pkg::ChDollar);
            send_rx_byte(8'($urandom));
          end
          1: begin
            send_rx_byte(mspv2fp_pkg::ChDollar);
            send_rx_byte(mspv2fp_pkg::ChX);
            send_rx_byte(8'($urandom));
          end
          2: begin
            send_rx_byte(mspv2fp_pkg::ChDollar);
            send_rx_byte(mspv2fp_pkg::ChDollar);
            send_rx_byte(mspv2fp_pkg::ChX);
          end
          default: begin
            // header with a random start padded with zero bytes, so the
            // length stays short; following bytes become payload and crc
            send_rx_byte(mspv2fp_pkg::ChDollar);
            send_rx_byte(mspv2fp_pkg::ChX);
            send_rx_byte(mspv2fp_pkg::ChCmd);
            cut = $urandom_range(1, 4);
            repeat (cut) send_rx_byte(8'($urandom));
            repeat (5 - cut) send_rx_byte(8'h00);
          end
        endcase
      end
    end
  endtask

  initial begin
    rst_ni     <= 1'b0;
    rx.valid   <= 1'b0;
    rx.rx_byte <= 8'h00;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_frames();
    test_broken_headers();
    test_long_frame();
    test_backpressure();
    test_random_traffic(1000);

    rx.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
